[src/counting_semaphore_priority_inherit_top_macros.svh]
// Assertion macros shared by the semaphore RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef COUNTING_SEMAPHORE_PRIORITY_INHERIT_TOP_MACROS_SVH
`define COUNTING_SEMAPHORE_PRIORITY_INHERIT_TOP_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define CSPI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent.
`define CSPI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/cspi_pkg.sv]
// Shared types, codes and constants for the counting semaphore.
// No dependencies.
package cspi_pkg;

  localparam int unsigned MaxProcs  = 64;
  localparam int unsigned CountBits = 16;
  localparam int unsigned PrioBits  = 8;

  localparam int unsigned CfgBits   = 16;
  localparam int unsigned CfgIdxW   = 2;

  localparam logic [CfgIdxW-1:0] CfgInitial = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMax     = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgInvPid  = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgNormPri = 2'd3;

  typedef enum logic [1:0] {
    KindAcquire  = 2'd0,
    KindRelease  = 2'd1,
    KindTry      = 2'd2,
    KindRegister = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StInvPid  = 2'd1,
    StBusy    = 2'd2,
    StInvState = 2'd3
  } status_e;

endpackage

[src/cspi_req_if.sv]
// Request and response channel interfaces of the semaphore.
// No dependencies.
interface cspi_req_if #(
  parameter int unsigned PidW = 6,
  parameter int unsigned PrioW = 8
);
  logic                    valid;
  logic                    ready;
  logic [1:0]              kind;
  logic [PidW-1:0]         pid;
  logic signed [PrioW-1:0] priority_req;

  modport source (output valid, kind, pid, priority_req, input ready);
  modport sink (input valid, kind, pid, priority_req, output ready);
endinterface

interface cspi_rsp_if #(
  parameter int unsigned PidW = 6,
  parameter int unsigned PrioW = 8,
  parameter int unsigned CountW = 16,
  parameter int unsigned WaitW = 7
);
  logic                    valid;
  logic                    ready;
  logic [1:0]              status;
  logic                    granted_valid;
  logic [PidW-1:0]         granted_pid;
  logic [CountW-1:0]       available;
  logic [WaitW-1:0]        waiting;
  logic signed [PrioW-1:0] effective_priority;
  logic signed [PrioW-1:0] base_priority;

  modport source (output valid, status, granted_valid, granted_pid, available, waiting,
                  effective_priority, base_priority, input ready);
  modport sink (input valid, status, granted_valid, granted_pid, available, waiting,
                effective_priority, base_priority, output ready);
endinterface

[src/cspi_prio_scan.sv]
// Priority recompute engine: one process entry per cycle over two passes (the raise pass only when a waiter exists).
// Depends on cspi_pkg and the macro header.
`include "counting_semaphore_priority_inherit_top_macros.svh"

module cspi_prio_scan #(
  parameter int unsigned MaxProcs = cspi_pkg::MaxProcs,
  parameter int unsigned PrioBits = cspi_pkg::PrioBits,
  localparam int unsigned PidW = $clog2(MaxProcs)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  output logic [PidW-1:0]            idx_o,
  output logic [PidW-1:0]            nidx_o,
  input  logic                       waiting_i,
  input  logic                       holding_i,
  input  logic                       known_i,
  input  logic signed [PrioBits-1:0] base_i,
  output logic                       eff_we_o,
  output logic signed [PrioBits-1:0] eff_o
);
  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SBest = 2'd1;
  localparam logic [1:0] SRaise = 2'd2;

  logic [1:0] state_q, state_d;
  logic [PidW-1:0] idx_q, idx_d;
  logic any_q, any_d;
  logic signed [PrioBits-1:0] best_q, best_d;
  logic last;

  assign last = (idx_q == PidW'(MaxProcs - 1));
  assign busy_o = (state_q != SIdle);
  assign idx_o = idx_q;
  // next entry, so the caller can prefetch its base priority
  assign nidx_o = idx_d;

  always_comb begin
    state_d = state_q;
    idx_d = idx_q;
    any_d = any_q;
    best_d = best_q;
    eff_we_o = 1'b0;
    eff_o = base_i;
    unique case (state_q)
      SIdle: begin
        if (start_i) begin
          state_d = SBest;
          idx_d = '0;
          any_d = 1'b0;
        end
      end
      SBest: begin
        // reset effective to base, find best waiter
        eff_we_o = known_i;
        if (waiting_i && (!any_q || base_i < best_q)) begin
          best_d = base_i;
          any_d = 1'b1;
        end
        idx_d = idx_q + 1'b1;
        if (last) begin
          idx_d = '0;
          state_d = any_d ? SRaise : SIdle;
        end
      end
      SRaise: begin
        eff_o = best_q;
        eff_we_o = known_i && holding_i && (best_q < base_i);
        idx_d = idx_q + 1'b1;
        if (last) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      idx_q <= '0;
      any_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d;
      any_q <= any_d;
    end
  end

  always_ff @(posedge clk_i) best_q <= best_d;

  `CSPI_ASSERT_IMP(a_raise_needs_any, clk_i, rst_ni, state_q == SRaise, any_q, "raise without waiter")
  `CSPI_ASSERT_IMP(a_raise_better, clk_i, rst_ni, state_q == SRaise && eff_we_o, eff_o < base_i, "raise not better")
  `CSPI_ASSERT_NEXT(a_start_idx, clk_i, rst_ni, state_q == SIdle && start_i, state_q == SBest && idx_q == '0, "scan start")
endmodule

[src/counting_semaphore_priority_inherit_top.sv]
// Top level of the counting semaphore with FIFO wait queue and priority inheritance.
// Depends on cspi_pkg, cspi_req_if/cspi_rsp_if, cspi_prio_scan and the macro header.
//
//  channel | dir | handshake   | payload
//  --------+-----+-------------+--------------------------------------------------
//  req     | in  | valid/ready | kind, pid, priority_req
//  rsp     | out | valid/ready | status, granted_*, available, waiting, priorities
//  cfg     | in  | cfg_we_i    | cfg_idx_i, cfg_data_i
//
// A valid request passes through read, execute, an optional grant step, the priority
// scan (with a raise pass when a waiter remains after the update) and output.
// The priority scan walks one process entry per cycle. Invalid pids go from the read
// step straight to output.
// Reset clears all flags at once; priority and hold tables are tagged by known bits.
// Ready drops from acceptance until the response is taken; the next request can be
// taken in the cycle after that.
`include "counting_semaphore_priority_inherit_top_macros.svh"

module counting_semaphore_priority_inherit_top #(
  parameter int unsigned MaxProcs = cspi_pkg::MaxProcs,
  parameter int unsigned CountBits = cspi_pkg::CountBits,
  parameter int unsigned PrioBits = cspi_pkg::PrioBits,
  localparam int unsigned PidW = $clog2(MaxProcs),
  localparam int unsigned WaitW = $clog2(MaxProcs + 1)
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [cspi_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [cspi_pkg::CfgBits-1:0] cfg_data_i,
  cspi_req_if.sink req,
  cspi_rsp_if.source rsp
);
  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SRead = 3'd1;
  localparam logic [2:0] SExec = 3'd2;
  localparam logic [2:0] SGrant = 3'd3;
  localparam logic [2:0] SScan = 3'd4;
  localparam logic [2:0] SOut = 3'd5;
  localparam logic [2:0] SDone = 3'd6;
  localparam logic [CountBits-1:0] HoldMax = '1;

  // configuration
  logic [15:0] init_q, max_q;
  logic [15:0] init_n, max_n;
  logic [5:0] inv_q;
  logic signed [7:0] norm_q;
  logic [CountBits-1:0] free_q;
  logic [CountBits:0] emax;
  logic [CountBits:0] emax_n;
  logic [CountBits:0] reload;

  assign emax = (max_q == '0) ? (CountBits+1)'(1) : (CountBits+1)'(max_q);

  // reload from the values that hold after this write
  assign init_n = (cfg_we_i && cfg_idx_i == cspi_pkg::CfgInitial) ? cfg_data_i : init_q;
  assign max_n = (cfg_we_i && cfg_idx_i == cspi_pkg::CfgMax) ? cfg_data_i : max_q;
  assign emax_n = (max_n == '0) ? (CountBits+1)'(1) : (CountBits+1)'(max_n);
  assign reload = ((CountBits+1)'(init_n) < emax_n) ? (CountBits+1)'(init_n) : emax_n;

  // per-process state
  logic [MaxProcs-1:0] known_q, wait_q, hold_nz_q;
  logic [CountBits-1:0] hold_mem [MaxProcs];
  logic signed [PrioBits-1:0] base_mem [MaxProcs];
  logic signed [PrioBits-1:0] eff_mem [MaxProcs];
  logic [PidW-1:0] fifo_mem [MaxProcs];
  logic [PidW-1:0] head_q;
  logic [WaitW-1:0] fill_q;

  logic [2:0] state_q;
  logic [1:0] kind_q;
  logic [5:0] pid_q;
  logic signed [PrioBits-1:0] preq_q;
  logic pid_ok;
  logic [PidW-1:0] p;
  logic [CountBits-1:0] hold_rd_q;
  logic [CountBits-1:0] hold_g_q;
  logic [CountBits-1:0] hold_cur;
  logic fresh_q;
  logic [PidW-1:0] head_rd_q, gpid_q;
  logic gval_q;
  logic [1:0] status_q;
  logic signed [PrioBits-1:0] pbase_q, peff_q;
  logic signed [PrioBits-1:0] base_rd_q, eff_rd_q, base_scan_q;

  logic scan_start, scan_busy, scan_we;
  logic scan_seen_q;
  logic [PidW-1:0] scan_idx, scan_nidx;
  logic signed [PrioBits-1:0] scan_eff;
  logic signed [PrioBits-1:0] scan_base;

  assign p = pid_q[PidW-1:0];
  assign pid_ok = (pid_q != inv_q) && ({26'd0, pid_q} < 32'(MaxProcs));
  assign scan_base = known_q[scan_idx] ? base_scan_q : norm_q;
  // a process seen for the first time holds nothing
  assign hold_cur = fresh_q ? '0 : hold_rd_q;

  cspi_prio_scan #(.MaxProcs(MaxProcs), .PrioBits(PrioBits)) u_scan (
    .clk_i, .rst_ni,
    .start_i(scan_start), .busy_o(scan_busy), .idx_o(scan_idx), .nidx_o(scan_nidx),
    .waiting_i(wait_q[scan_idx]), .holding_i(hold_nz_q[scan_idx]),
    .known_i(known_q[scan_idx]), .base_i(scan_base),
    .eff_we_o(scan_we), .eff_o(scan_eff)
  );

  assign req.ready = (state_q == SIdle);
  assign rsp.valid = (state_q == SDone);
  // start the scan once per valid request
  assign scan_start = (state_q == SScan) && !scan_busy && !scan_seen_q;

  // registered reads of per-process tables
  always_ff @(posedge clk_i) begin
    hold_rd_q <= hold_mem[p];
    hold_g_q <= hold_mem[head_rd_q];
    head_rd_q <= fifo_mem[head_q];
    base_rd_q <= base_mem[p];
    eff_rd_q <= eff_mem[p];
    base_scan_q <= base_mem[scan_nidx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      init_q <= '0;
      max_q <= 16'd1;
      inv_q <= '0;
      norm_q <= '0;
      free_q <= '0;
      known_q <= '0;
      wait_q <= '0;
      hold_nz_q <= '0;
      head_q <= '0;
      fill_q <= '0;
      scan_seen_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          cspi_pkg::CfgInitial: init_q <= cfg_data_i;
          cspi_pkg::CfgMax: max_q <= cfg_data_i;
          cspi_pkg::CfgInvPid: inv_q <= cfg_data_i[5:0];
          cspi_pkg::CfgNormPri: norm_q <= PrioBits'(cfg_data_i);
          default: ;
        endcase
        free_q <= CountBits'(reload);
      end
      unique case (state_q)
        SIdle: if (req.valid) state_q <= SRead;
        SRead: begin
          if (!pid_ok) state_q <= SOut;
          else begin
            state_q <= SExec;
            if (!known_q[p]) begin
              known_q[p] <= 1'b1;
            end
          end
        end
        SExec: begin
          state_q <= SScan;
          scan_seen_q <= 1'b0;
          if (kind_q == cspi_pkg::KindAcquire || kind_q == cspi_pkg::KindTry) begin
            if (free_q != '0) begin
              free_q <= free_q - 1'b1;
              hold_nz_q[p] <= 1'b1;
            end else if (kind_q == cspi_pkg::KindAcquire && !wait_q[p]
                         && fill_q < WaitW'(MaxProcs)) begin
              fill_q <= fill_q + 1'b1;
              wait_q[p] <= 1'b1;
            end
          end else if (kind_q == cspi_pkg::KindRelease) begin
            if (hold_cur <= CountBits'(1)) hold_nz_q[p] <= 1'b0;
            if (fill_q != '0) begin
              state_q <= SGrant;
              head_q <= head_q + 1'b1;
              fill_q <= fill_q - 1'b1;
            end else if ((CountBits+1)'(free_q) < emax) begin
              free_q <= free_q + 1'b1;
            end
          end
        end
        SGrant: begin
          wait_q[gpid_q] <= 1'b0;
          known_q[gpid_q] <= 1'b1;
          hold_nz_q[gpid_q] <= 1'b1;
          state_q <= SScan;
        end
        SScan: begin
          if (scan_busy) scan_seen_q <= 1'b1;
          else if (scan_seen_q) state_q <= SOut;
        end
        SOut: state_q <= SDone;
        SDone: if (rsp.ready) state_q <= SIdle;
        default: state_q <= SIdle;
      endcase
    end
  end

  // payload and table writes
  always_ff @(posedge clk_i) begin
    if (state_q == SIdle && req.valid) begin
      kind_q <= req.kind;
      pid_q <= req.pid;
      preq_q <= req.priority_req;
      gval_q <= 1'b0;
      gpid_q <= '0;
      status_q <= cspi_pkg::StOk;
    end
    if (state_q == SRead) begin
      fresh_q <= !known_q[p];
      if (!pid_ok) status_q <= cspi_pkg::StInvPid;
      else begin
        if (!known_q[p]) hold_mem[p] <= '0;
        if (kind_q == cspi_pkg::KindRegister) begin
          base_mem[p] <= preq_q;
          eff_mem[p] <= preq_q;
        end else if (!known_q[p]) begin
          base_mem[p] <= norm_q;
          eff_mem[p] <= norm_q;
        end
      end
    end
    if (state_q == SExec) begin
      if (kind_q == cspi_pkg::KindAcquire || kind_q == cspi_pkg::KindTry) begin
        if (free_q != '0) begin
          if (hold_cur != HoldMax) hold_mem[p] <= hold_cur + 1'b1;
        end else begin
          status_q <= cspi_pkg::StBusy;
          if (kind_q == cspi_pkg::KindAcquire && !wait_q[p] && fill_q < WaitW'(MaxProcs))
            fifo_mem[PidW'(head_q + PidW'(fill_q))] <= p;
        end
      end else if (kind_q == cspi_pkg::KindRelease) begin
        if (hold_cur != '0) hold_mem[p] <= hold_cur - 1'b1;
        if (fill_q != '0) begin
          gval_q <= 1'b1;
          gpid_q <= head_rd_q;
        end else if (!((CountBits+1)'(free_q) < emax)) begin
          status_q <= cspi_pkg::StInvState;
        end
      end
    end
    if (state_q == SGrant) begin
      if (!known_q[gpid_q]) begin
        base_mem[gpid_q] <= norm_q;
        eff_mem[gpid_q] <= norm_q;
        hold_mem[gpid_q] <= CountBits'(1);
      end else if (gpid_q == p) begin
        if (hold_cur - (hold_cur != '0 ? CountBits'(1) : '0) != HoldMax)
          hold_mem[gpid_q] <= hold_cur - (hold_cur != '0 ? CountBits'(1) : '0) + 1'b1;
      end else begin
        if (hold_g_q != HoldMax) hold_mem[gpid_q] <= hold_g_q + 1'b1;
      end
    end
    if (scan_we) eff_mem[scan_idx] <= scan_eff;
    if (state_q == SOut) begin
      pbase_q <= ({26'd0, pid_q} < 32'(MaxProcs) && known_q[p]) ? base_rd_q : norm_q;
      peff_q <= ({26'd0, pid_q} < 32'(MaxProcs) && known_q[p]) ? eff_rd_q : norm_q;
    end
  end

  assign rsp.status = status_q;
  assign rsp.granted_valid = gval_q;
  assign rsp.granted_pid = gpid_q;
  assign rsp.available = free_q;
  assign rsp.waiting = fill_q;
  assign rsp.effective_priority = peff_q;
  assign rsp.base_priority = pbase_q;

  `CSPI_ASSERT_IMP(a_ready_idle, clk_i, rst_ni, req.ready, !rsp.valid, "ready while result held")
  `CSPI_ASSERT_IMP(a_fill_range, clk_i, rst_ni, 1'b1, fill_q <= WaitW'(MaxProcs), "queue overfill")
  `CSPI_ASSERT_IMP(a_wait_count, clk_i, rst_ni, state_q == SIdle, $countones(wait_q) == 32'(fill_q), "wait flags mismatch")
  `CSPI_ASSERT_IMP(a_grant_flag, clk_i, rst_ni, rsp.valid && rsp.granted_valid, rsp.status == cspi_pkg::StOk, "grant with error")
endmodule
